/* hdl/tbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants of the threshold blob centroid
// Field widths, register indexes, reset values and the frame-sum record that
// travels from the pixel front end to the divider.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int POS_W      = 10;
    localparam int POS_SPAN   = 1024;
    localparam int SUM_W      = 30;
    localparam int CNT_W      = 21;
    localparam int RES_W      = 19;
    localparam int FRAC_W     = 8;
    localparam int DVD_W      = SUM_W + FRAC_W;
    localparam int DIV_STEPS  = RES_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET   = 8'd150;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 11'd640;

    // -1.0 in 8 fraction bits
    localparam logic signed [RES_W-1:0] CENTROID_NONE = -19'sd256;
    localparam logic signed [RES_W-1:0] CENTROID_MAX  = 19'sd261888;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } t_frame_sums;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_div_state;

endpackage

/* hdl/tbc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_if: channel interfaces of the threshold blob centroid
// Pixel stream, centroid results and register writes, each valid/ready.
// ----------------------------------------------------------------------------
interface tbc_pixel_if import tbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_end;

    modport source (output valid, output pixel_value, output frame_end, input ready);
    modport sink   (input valid, input pixel_value, input frame_end, output ready);
endinterface

interface tbc_result_if import tbc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] centroid_x;
    logic signed [RES_W-1:0] centroid_y;
    logic                    found;

    modport source (output valid, output centroid_x, output centroid_y, output found,
                    input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, input found,
                    output ready);
endinterface

interface tbc_cfg_if import tbc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/tbc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_front: pixel front end
// Tracks raster position, thresholds each pixel and accumulates the white
// pixel sums; hands the frame sums to the queue on the last pixel.
// ----------------------------------------------------------------------------
module tbc_front import tbc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel_value,
    input  logic             i_frame_end,
    input  logic [THR_W-1:0] i_pixel_threshold,
    input  logic [FW_W-1:0]  i_frame_width,
    input  t_queue_status    i_queue,
    output logic             o_push,
    output t_frame_sums      o_sums
);

    localparam int WIDTH_LIM  = (MAX_WIDTH < POS_SPAN) ? MAX_WIDTH : POS_SPAN;
    localparam int HEIGHT_LIM = (MAX_HEIGHT < POS_SPAN) ? MAX_HEIGHT : POS_SPAN;
    localparam logic [FW_W-1:0] WIDTH_LIM_V  = FW_W'(WIDTH_LIM);
    localparam logic [FW_W-1:0] HEIGHT_LIM_V = FW_W'(HEIGHT_LIM);

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [SUM_W-1:0] r_sum_x, n_sum_x;
    logic [SUM_W-1:0] r_sum_y, n_sum_y;
    logic [CNT_W-1:0] r_count, n_count;

    logic [FW_W-1:0]  width_eff;
    logic [FW_W-1:0]  col_inc;
    logic [FW_W-1:0]  row_inc;
    logic             accept;
    logic             white;
    logic [SUM_W-1:0] add_x;
    logic [SUM_W-1:0] add_y;
    logic [CNT_W-1:0] add_count;

    always_comb begin
        if (i_frame_width == '0) begin
            width_eff = FW_W'(1);
        end else if (i_frame_width > WIDTH_LIM_V) begin
            width_eff = WIDTH_LIM_V;
        end else begin
            width_eff = i_frame_width;
        end
    end

    assign o_ready = !i_queue.full;
    assign accept  = i_valid && o_ready;
    // count saturates at 2^20 white pixels
    assign white   = (i_pixel_value > i_pixel_threshold) && !r_count[CNT_W-1];
    assign col_inc = {1'b0, r_col} + FW_W'(1);
    assign row_inc = {1'b0, r_row} + FW_W'(1);

    assign add_x     = white ? r_sum_x + SUM_W'(r_col) : r_sum_x;
    assign add_y     = white ? r_sum_y + SUM_W'(r_row) : r_sum_y;
    assign add_count = white ? r_count + CNT_W'(1) : r_count;

    assign o_push       = accept && i_frame_end;
    assign o_sums.sum_x = add_x;
    assign o_sums.sum_y = add_y;
    assign o_sums.count = add_count;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        n_count = r_count;
        if (accept) begin
            n_sum_x = add_x;
            n_sum_y = add_y;
            n_count = add_count;
            if (col_inc >= width_eff) begin
                n_col = '0;
                n_row = (row_inc >= HEIGHT_LIM_V) ? '0 : row_inc[POS_W-1:0];
            end else begin
                n_col = col_inc[POS_W-1:0];
            end
            if (i_frame_end) begin
                n_col   = '0;
                n_row   = '0;
                n_sum_x = '0;
                n_sum_y = '0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_count <= n_count;
        end
    end

endmodule

/* hdl/tbc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_queue: frame-sum queue
// Two-entry FIFO between the pixel front end and the divider.
// ----------------------------------------------------------------------------
module tbc_queue import tbc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_frame_sums   i_data,
    input  logic          i_pop,
    output t_frame_sums   o_data,
    output t_queue_status o_status
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    t_frame_sums       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              do_push;
    logic              do_pop;

    assign o_status.empty = (r_fill == '0);
    assign o_status.full  = (r_fill == FILL_MAX);
    assign o_data         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

/* hdl/tbc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_divider: centroid divider and output register
// Restoring division of both coordinate sums by the white count, one quotient
// bit per cycle for x and y together, then a registered result stage.
// ----------------------------------------------------------------------------
module tbc_divider import tbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_queue_status           i_queue,
    input  t_frame_sums             i_sums,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [RES_W-1:0] o_centroid_x,
    output logic signed [RES_W-1:0] o_centroid_y,
    output logic                    o_found
);

    localparam int TOP_W = DVD_W - RES_W;

    t_div_state       r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0] r_rem_x, n_rem_x;
    logic [CNT_W-1:0] r_rem_y, n_rem_y;
    logic [RES_W-1:0] r_q_x, n_q_x;
    logic [RES_W-1:0] r_q_y, n_q_y;
    logic [CNT_W-1:0] r_divisor, n_divisor;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic signed [RES_W-1:0] r_out_x, n_out_x;
    logic signed [RES_W-1:0] r_out_y, n_out_y;
    logic             r_out_found, n_out_found;

    logic [DVD_W-1:0] dvd_x;
    logic [DVD_W-1:0] dvd_y;
    logic [CNT_W:0]   trial_x;
    logic [CNT_W:0]   trial_y;
    logic [CNT_W:0]   diff_x;
    logic [CNT_W:0]   diff_y;
    logic             ge_x;
    logic             ge_y;

    assign dvd_x = {i_sums.sum_x, FRAC_W'(0)};
    assign dvd_y = {i_sums.sum_y, FRAC_W'(0)};

    assign trial_x = {r_rem_x, r_q_x[RES_W-1]};
    assign trial_y = {r_rem_y, r_q_y[RES_W-1]};
    assign diff_x  = trial_x - {1'b0, r_divisor};
    assign diff_y  = trial_y - {1'b0, r_divisor};
    assign ge_x    = trial_x >= {1'b0, r_divisor};
    assign ge_y    = trial_y >= {1'b0, r_divisor};

    assign o_valid      = r_out_valid;
    assign o_centroid_x = r_out_x;
    assign o_centroid_y = r_out_y;
    assign o_found      = r_out_found;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_q_x       = r_q_x;
        n_q_y       = r_q_y;
        n_divisor   = r_divisor;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_found = r_out_found;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_queue.empty) begin
                    o_pop     = 1'b1;
                    n_divisor = i_sums.count;
                    n_found   = (i_sums.count != '0);
                    // quotient fits RES_W bits, so the top part is below the divisor
                    n_rem_x   = CNT_W'(dvd_x[DVD_W-1 -: TOP_W]);
                    n_rem_y   = CNT_W'(dvd_y[DVD_W-1 -: TOP_W]);
                    n_q_x     = dvd_x[RES_W-1:0];
                    n_q_y     = dvd_y[RES_W-1:0];
                    n_step    = '0;
                    n_state   = (i_sums.count != '0) ? S_DIV : S_HOLD;
                end
            end
            S_DIV: begin
                n_rem_x = ge_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
                n_rem_y = ge_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];
                n_q_x   = {r_q_x[RES_W-2:0], ge_x};
                n_q_y   = {r_q_y[RES_W-2:0], ge_y};
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_found ? $signed(r_q_x) : CENTROID_NONE;
                    n_out_y     = r_found ? $signed(r_q_y) : CENTROID_NONE;
                    n_out_found = r_found;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_rem_x     <= n_rem_x;
        r_rem_y     <= n_rem_y;
        r_q_x       <= n_q_x;
        r_q_y       <= n_q_y;
        r_divisor   <= n_divisor;
        r_found     <= n_found;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_found <= n_out_found;
    end

endmodule

/* hdl/threshold_blob_centroid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_blob_centroid: binary threshold centroid of a raster frame
// Pixels in raster order; one centroid result per frame.
// ----------------------------------------------------------------------------
// i_pix carries one pixel per transaction with a frame_end flag on the last
// pixel of the frame. o_res gives one transaction per frame: mean column and
// mean row of the pixels above threshold, signed with 8 fraction bits,
// truncated, and found; with no white pixel both coordinates are -256 and
// found is 0. i_cfg writes register 0 (pixel threshold) or 1 (frame width);
// it is always ready, and the user must write it only while the block is idle;
// the block does not enforce this. Pixels are taken one per cycle while the
// queue is not full. On the last pixel the frame sums go into a two-entry
// queue, from which a shared restoring divider takes each frame and divides
// x and y together. i_pix stalls only when the queue holds two unfinished frames.
// When o_res is stalled the result waits in the output register while the
// divider finishes the next frame behind it.
// Reset (synchronous, active low) restores threshold 150 and width 640, and
// clears position counters, sums, queue and result.
// ----------------------------------------------------------------------------
module threshold_blob_centroid import tbc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbc_pixel_if.sink    i_pix,
    tbc_result_if.source o_res,
    tbc_cfg_if.sink      i_cfg
);

    logic [THR_W-1:0] r_pixel_threshold;
    logic [FW_W-1:0]  r_frame_width;

    t_queue_status queue_status;
    t_frame_sums   push_sums;
    t_frame_sums   head_sums;
    logic          push;
    logic          pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_threshold <= THRESHOLD_RESET;
            r_frame_width     <= FRAME_WIDTH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PIXEL_THRESHOLD: r_pixel_threshold <= i_cfg.data[THR_W-1:0];
                CFG_FRAME_WIDTH:     r_frame_width     <= i_cfg.data[FW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_pix.valid),
        .o_ready           (i_pix.ready),
        .i_pixel_value     (i_pix.pixel_value),
        .i_frame_end       (i_pix.frame_end),
        .i_pixel_threshold (r_pixel_threshold),
        .i_frame_width     (r_frame_width),
        .i_queue           (queue_status),
        .o_push            (push),
        .o_sums            (push_sums)
    );

    tbc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_sums),
        .i_pop    (pop),
        .o_data   (head_sums),
        .o_status (queue_status)
    );

    tbc_divider u_divider (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue      (queue_status),
        .i_sums       (head_sums),
        .o_pop        (pop),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_centroid_x (o_res.centroid_x),
        .o_centroid_y (o_res.centroid_y),
        .o_found      (o_res.found)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_status.full)
        else $error("frame sums pushed into a full queue");

    a_none_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |->
            (o_res.centroid_x == CENTROID_NONE && o_res.centroid_y == CENTROID_NONE))
        else $error("empty frame result is not -1.0");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.found) |->
            (o_res.centroid_x >= 0 && o_res.centroid_x <= CENTROID_MAX &&
             o_res.centroid_y >= 0 && o_res.centroid_y <= CENTROID_MAX))
        else $error("centroid outside the position range");

    a_pop_only_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !queue_status.empty)
        else $error("divider popped an empty queue");
`endif

endmodule
